### rtl/lif_pkg.sv
// ----------------------------------------------------------------------------
// lif_pkg
// Shared types, constants and saturating fixed-point helpers for the
// leaky integrate-and-fire neuron step block.
// ----------------------------------------------------------------------------
`default_nettype none

package lif_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_REST_VOLTAGE        = 3'd0;
   localparam logic [2:0] REG_RESET_VOLTAGE       = 3'd1;
   localparam logic [2:0] REG_MEMBRANE_RESISTANCE = 3'd2;
   localparam logic [2:0] REG_DECAY_FACTOR        = 3'd3;
   localparam logic [2:0] REG_OFFSET_CURRENT      = 3'd4;
   localparam logic [2:0] REG_REFRACTORY_STEPS    = 3'd5;

   // action codes
   localparam logic [1:0] ACT_TIMESTEP = 2'd0;
   localparam logic [1:0] ACT_SPIKED   = 2'd1;
   localparam logic [1:0] ACT_MARK     = 2'd2;

   // s16.15 constants
   localparam logic signed [31:0] FIRE_VOLTAGE = 32'sd33554432; // 1024.0
   localparam logic signed [31:0] MARK_VOLTAGE = 32'sd32768000; // 1000.0

   localparam int FRAC_BITS = 15;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;   // take a request transaction
      logic sum1;      // cur = exc - inh
      logic sum2;      // cur += bias
      logic sum3;      // cur += offset
      logic mul1;      // prod = cur * resistance
      logic alpha;     // alpha = prod + rest
      logic diff;      // diff = alpha - v
      logic mul2;      // prod = decay * diff
      logic fin;       // v = alpha - prod
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic need_update; // pending request runs the full voltage update
   } status_type;

   // clamp a 33-bit sum to 32 bits
   function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
      logic signed [31:0] r;
      if (s[32] != s[31]) begin
         r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   // floor-shift a 64-bit product by FRAC_BITS and clamp to 32 bits
   function automatic logic signed [31:0] sat_prod(input logic signed [63:0] p);
      logic signed [63:0] q;
      logic signed [31:0] r;
      q = p >>> FRAC_BITS;
      if ((q[63:31] != {33{1'b0}}) && (q[63:31] != {33{1'b1}})) begin
         r = q[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = q[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/lif_ctrl.sv
// ----------------------------------------------------------------------------
// lif_ctrl
// Sequencer for the neuron step: accepts a request, walks the datapath
// through the update steps when the request needs them and holds the response until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lif_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   input  wire lif_pkg::status_type status,
   output lif_pkg::cmd_type      cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SUM1  = 4'd1;
   localparam logic [3:0] S_SUM2  = 4'd2;
   localparam logic [3:0] S_SUM3  = 4'd3;
   localparam logic [3:0] S_MUL1  = 4'd4;
   localparam logic [3:0] S_ALPHA = 4'd5;
   localparam logic [3:0] S_DIFF  = 4'd6;
   localparam logic [3:0] S_MUL2  = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = status.need_update ? S_SUM1 : S_OUT;
            end
         end
         S_SUM1: begin
            cmd.sum1 = 1'b1;
            state_in = S_SUM2;
         end
         S_SUM2: begin
            cmd.sum2 = 1'b1;
            state_in = S_SUM3;
         end
         S_SUM3: begin
            cmd.sum3 = 1'b1;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_ALPHA;
         end
         S_ALPHA: begin
            cmd.alpha = 1'b1;
            state_in  = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/lif_dp.sv
// ----------------------------------------------------------------------------
// lif_dp
// Datapath: configuration registers, neuron state, saturating adders and
// one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module lif_dp (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_we,
   input  wire  [2:0]            csr_index,
   input  wire  [31:0]           csr_wdata,
   input  wire  [167:0]          req_tdata,
   output logic [63:0]           rsp_tdata,
   input  wire lif_pkg::cmd_type cmd,
   output lif_pkg::status_type   status
);

   // configuration
   logic signed [31:0] rest_ff, reset_v_ff, resist_ff, offset_ff;
   logic        [15:0] decay_ff, refr_steps_ff;

   // neuron state
   logic signed [31:0] voltage_ff, voltage_in;
   logic signed [31:0] prev_ff, prev_in;
   logic        [15:0] refr_ff, refr_in;

   // working registers
   logic signed [31:0] exc_ff, inh_ff, bias_ff;
   logic signed [31:0] cur_ff, cur_in;
   logic signed [31:0] alpha_ff, alpha_in;
   logic signed [31:0] diff_ff, diff_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] mul_a, mul_b;

   // request fields
   logic        [1:0]  f_action;
   logic signed [31:0] f_exc, f_teacher, f_rst, f_inh, f_bias;

   assign f_action  = req_tdata[1:0];
   assign f_exc     = req_tdata[33:2];
   assign f_teacher = req_tdata[65:34];
   assign f_rst     = req_tdata[97:66];
   assign f_inh     = req_tdata[129:98];
   assign f_bias    = req_tdata[161:130];

   assign status.need_update = (f_action == lif_pkg::ACT_TIMESTEP) && (refr_ff == 16'd0);
   assign rsp_tdata = {prev_ff, voltage_ff};

   // shared multiplier
   assign mul_a   = cmd.mul2 ? $signed({16'd0, decay_ff}) : cur_ff;
   assign mul_b   = cmd.mul2 ? diff_ff : resist_ff;
   assign prod_in = mul_a * mul_b;

   always_comb begin
      voltage_in = voltage_ff;
      prev_in    = prev_ff;
      refr_in    = refr_ff;
      cur_in     = cur_ff;
      alpha_in   = alpha_ff;
      diff_in    = diff_ff;
      if (cmd.capture) begin
         case (f_action)
            lif_pkg::ACT_TIMESTEP: begin
               prev_in = voltage_ff;
               if (refr_ff != 16'd0) begin
                  refr_in = refr_ff - 16'd1;
               end else if (f_rst > 0) begin
                  voltage_in = reset_v_ff;
               end else if (f_teacher > 0) begin
                  voltage_in = lif_pkg::FIRE_VOLTAGE;
               end
            end
            lif_pkg::ACT_SPIKED: begin
               voltage_in = reset_v_ff;
               refr_in    = refr_steps_ff;
            end
            lif_pkg::ACT_MARK: begin
               prev_in = lif_pkg::MARK_VOLTAGE;
            end
            default: begin
            end
         endcase
      end
      if (cmd.sum1) begin
         cur_in = lif_pkg::sat33(33'(exc_ff) - 33'(inh_ff));
      end
      if (cmd.sum2) begin
         cur_in = lif_pkg::sat33(33'(cur_ff) + 33'(bias_ff));
      end
      if (cmd.sum3) begin
         cur_in = lif_pkg::sat33(33'(cur_ff) + 33'(offset_ff));
      end
      if (cmd.alpha) begin
         alpha_in = lif_pkg::sat33(33'(lif_pkg::sat_prod(prod_ff)) + 33'(rest_ff));
      end
      if (cmd.diff) begin
         diff_in = lif_pkg::sat33(33'(alpha_ff) - 33'(voltage_ff));
      end
      if (cmd.fin) begin
         voltage_in = lif_pkg::sat33(33'(alpha_ff) - 33'(lif_pkg::sat_prod(prod_ff)));
      end
   end

   // state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         voltage_ff    <= '0;
         prev_ff       <= '0;
         refr_ff       <= '0;
         rest_ff       <= '0;
         reset_v_ff    <= '0;
         resist_ff     <= '0;
         decay_ff      <= '0;
         offset_ff     <= '0;
         refr_steps_ff <= '0;
      end else begin
         voltage_ff <= voltage_in;
         prev_ff    <= prev_in;
         refr_ff    <= refr_in;
         if (csr_we) begin
            unique case (csr_index)
               lif_pkg::REG_REST_VOLTAGE:        rest_ff       <= csr_wdata;
               lif_pkg::REG_RESET_VOLTAGE:       reset_v_ff    <= csr_wdata;
               lif_pkg::REG_MEMBRANE_RESISTANCE: resist_ff     <= csr_wdata;
               lif_pkg::REG_DECAY_FACTOR:        decay_ff      <= csr_wdata[15:0];
               lif_pkg::REG_OFFSET_CURRENT:      offset_ff     <= csr_wdata;
               lif_pkg::REG_REFRACTORY_STEPS:    refr_steps_ff <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   // working payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         exc_ff  <= (f_rst > 0) ? 32'sd0 : f_exc;  // forced reset drops excitation
         inh_ff  <= f_inh;
         bias_ff <= f_bias;
      end
      if (cmd.mul1 || cmd.mul2) begin
         prod_ff <= prod_in;
      end
      cur_ff   <= cur_in;
      alpha_ff <= alpha_in;
      diff_ff  <= diff_in;
   end

endmodule

`default_nettype wire

### rtl/lif_neuron_teacher_step.sv
// Sequence: a timestep outside refractory, once the request is taken, runs
//   eight datapath steps through one shared 32x32 multiplier, then output.
// Other actions and refractory timesteps respond in the cycle after the request is taken.
// Transactions: one at a time; the next request is taken the cycle after
//   the response is taken.
// Reset: synchronous, active high; clears voltage, history, refractory and config.
// ----------------------------------------------------------------------------
// lif_neuron_teacher_step
// Leaky integrate-and-fire neuron, closed-form update in s16.15 fixed point,
// with teacher and forced-reset inputs.
// ----------------------------------------------------------------------------
`default_nettype none

module lif_neuron_teacher_step (
   input  wire          clock,
   input  wire          reset,
   // configuration write port
   input  wire          csr_we,
   input  wire  [2:0]   csr_index,
   input  wire  [31:0]  csr_wdata,
   // request stream
   input  wire          req_tvalid,
   output logic         req_tready,
   // req_tdata, low bit up: action[1:0], excitatory_input[31:0],
   // teacher_input[31:0], reset_input[31:0], inhibitory_input[31:0],
   // bias_current[31:0], zero pad[5:0]
   input  wire  [167:0] req_tdata,
   // response stream
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // rsp_tdata, low bit up: membrane_voltage[31:0], history_voltage[31:0]
   output logic [63:0]  rsp_tdata
);

   lif_pkg::cmd_type    cmd;
   lif_pkg::status_type status;

   // Controller: IDLE -> (update steps) -> OUT. Actions that only touch the
   // state (spike, mark, refractory countdown) are finished in the capture
   // cycle and go straight to OUT.
   lif_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: response data is the live state, stable while OUT waits
   // since nothing else is commanded until the transaction completes.
   lif_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

### bench/lif_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_step_checker
// Watches the register port and both streams of the neuron step block. It
// keeps its own copy of the neuron state, works out the voltage pair that each
// request transaction must produce, and compares each response against the
// oldest pair still due.
// ----------------------------------------------------------------------------

module lif_step_checker (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_we,
   input  wire  [2:0]   csr_index,
   input  wire  [31:0]  csr_wdata,
   input  wire          req_tvalid,
   input  wire          req_tready,
   // req_tdata, low bit up: action[1:0], excitatory_input[31:0],
   // teacher_input[31:0], reset_input[31:0], inhibitory_input[31:0],
   // bias_current[31:0], zero pad[5:0]
   input  wire  [167:0] req_tdata,
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   // rsp_tdata, low bit up: membrane_voltage[31:0], history_voltage[31:0]
   input  wire  [63:0]  rsp_tdata,
   output int           mismatch_count,
   output int           outstanding
);

   typedef struct {
      logic signed [31:0] membrane;
      logic signed [31:0] history;
   } neuron_view_type;

   // register copies
   logic signed [31:0] rest_v, reset_v, resistance, offset_i;
   logic [15:0]        decay, refr_load;
   // neuron state copies
   logic signed [31:0] volt, volt_prev;
   logic [15:0]        refr_left;

   neuron_view_type voltage_due[$];
   int mismatches = 0;

   function automatic logic signed [31:0] clamp32(input longint x);
      if (x > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (x < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   // product shifted down with floor rounding, then clamped
   function automatic logic signed [31:0] mul_q15(input longint a, input longint b);
      longint p;
      p = a * b;
      return clamp32(p >>> lif_pkg::FRAC_BITS);
   endfunction

   task automatic neuron_advance(input logic [167:0] d, output neuron_view_type r);
      logic [1:0]         act;
      logic signed [31:0] exc, teach, force_rst, inh, bias, cur, alpha, spread;
      act       = d[1:0];
      exc       = d[33:2];
      teach     = d[65:34];
      force_rst = d[97:66];
      inh       = d[129:98];
      bias      = d[161:130];
      case (act)
         lif_pkg::ACT_TIMESTEP: begin
            volt_prev = volt;
            if (refr_left == 16'd0) begin
               if (teach > 0) volt = lif_pkg::FIRE_VOLTAGE;
               // forced reset overrides teacher and drops excitation
               if (force_rst > 0) begin
                  volt = reset_v;
                  exc  = '0;
               end
               cur    = clamp32(longint'(exc) - longint'(inh));
               cur    = clamp32(longint'(cur) + longint'(bias));
               cur    = clamp32(longint'(cur) + longint'(offset_i));
               alpha  = clamp32(longint'(mul_q15(cur, resistance)) + longint'(rest_v));
               spread = clamp32(longint'(alpha) - longint'(volt));
               volt   = clamp32(longint'(alpha) - longint'(mul_q15(decay, spread)));
            end else begin
               refr_left = refr_left - 16'd1;
            end
         end
         lif_pkg::ACT_SPIKED: begin
            volt      = reset_v;
            refr_left = refr_load;
         end
         lif_pkg::ACT_MARK: begin
            volt_prev = lif_pkg::MARK_VOLTAGE;
         end
         default: ;
      endcase
      r.membrane = volt;
      r.history  = volt_prev;
   endtask

   task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t lif check: %s expected %h got %h", $time, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      neuron_view_type want, got;
      if (reset) begin
         rest_v     = '0;
         reset_v    = '0;
         resistance = '0;
         decay      = '0;
         offset_i   = '0;
         refr_load  = '0;
         volt       = '0;
         volt_prev  = '0;
         refr_left  = '0;
         voltage_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               lif_pkg::REG_REST_VOLTAGE:        rest_v     = csr_wdata;
               lif_pkg::REG_RESET_VOLTAGE:       reset_v    = csr_wdata;
               lif_pkg::REG_MEMBRANE_RESISTANCE: resistance = csr_wdata;
               lif_pkg::REG_DECAY_FACTOR:        decay      = csr_wdata[15:0];
               lif_pkg::REG_OFFSET_CURRENT:      offset_i   = csr_wdata;
               lif_pkg::REG_REFRACTORY_STEPS:    refr_load  = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            neuron_advance(req_tdata, want);
            voltage_due.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.membrane = rsp_tdata[31:0];
            got.history  = rsp_tdata[63:32];
            if (voltage_due.size() == 0) begin
               flag("response with nothing due, membrane", '0, got.membrane);
            end else begin
               want = voltage_due.pop_front();
               if (got.membrane !== want.membrane)
                  flag("membrane voltage", want.membrane, got.membrane);
               if (got.history !== want.history)
                  flag("history voltage", want.history, got.history);
            end
         end
      end
      outstanding    <= voltage_due.size();
      mismatch_count <= mismatches;
   end

endmodule

### bench/tb_lif_neuron_teacher_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lif_neuron_teacher_step
// Drives the neuron step block with a directed opening (field extremes, every
// action, teacher/reset interplay, refractory countdown) and then several
// randomized register settings with mostly physiological currents mixed with
// full-range and saturating values. Bursty request traffic, a pacing pattern
// on the response side and one long response hold-off. Checking lives in
// lif_step_checker; this module only stimulates and reports.
// ----------------------------------------------------------------------------

module tb_lif_neuron_teacher_step;

   // action code the block leaves undefined: must change nothing
   localparam logic [1:0] ACT_UNUSED   = 2'd3;
   // register index with no register behind it
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE_Q15 = 32'sd32768;

   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 185;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 20;

   // response pacing styles
   localparam int PACE_OPEN   = 0;
   localparam int PACE_COIN   = 1;
   localparam int PACE_SPARSE = 2;
   localparam int PACE_RUNS   = 3;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          csr_we     = 1'b0;
   logic [2:0]    csr_index  = '0;
   logic [31:0]   csr_wdata  = '0;
   logic          req_tvalid = 1'b0;
   wire           req_tready;
   // req_tdata, low bit up: action[1:0], excitatory_input[31:0],
   // teacher_input[31:0], reset_input[31:0], inhibitory_input[31:0],
   // bias_current[31:0], zero pad[5:0]
   logic [167:0]  req_tdata  = '0;
   wire           rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // rsp_tdata, low bit up: membrane_voltage[31:0], history_voltage[31:0]
   wire  [63:0]   rsp_tdata;

   int mismatch_count;
   int outstanding;

   int burst_left = 0;   // transactions left before the next sender gap
   bit req_live   = 0;   // tvalid left high at the end of the last offer
   bit hold_rsp   = 0;   // asks the response side for one long hold-off

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   lif_neuron_teacher_step uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   lif_step_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Watchdog, sized against the slowest legal run (about 1150 transactions,
   // each with its compute steps, a random sender gap and a sparse response
   // pattern, plus the one hold-off of RSP_HOLD_CYCLES).
   initial begin
      #8_000_000;
      $display("tb_lif_neuron_teacher_step: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: pacing segments of random style and length. A hold-off
   // request from the stimulus keeps tready low for RSP_HOLD_CYCLES so the
   // block backs up and stalls its request side.
   // ------------------------------------------------------------------------
   initial begin : rsp_pacing
      int seg_left;
      int pace;
      int hold_left;
      seg_left  = 0;
      pace      = PACE_OPEN;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp  = 0;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (reset || hold_left != 0) begin
            if (hold_left != 0) hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               pace     = $urandom_range(PACE_OPEN, PACE_RUNS);
               seg_left = $urandom_range(8, 80);
            end
            seg_left--;
            case (pace)
               PACE_OPEN:   rsp_tready <= 1'b1;
               PACE_COIN:   rsp_tready <= ($urandom_range(0, 1) == 0);
               PACE_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= ((seg_left % 6) < 3);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side helpers
   // ------------------------------------------------------------------------

   // One request transaction. In a burst it returns in the time step of the accepting
   // edge with tvalid still high; otherwise tvalid drops and it returns after a random gap.
   task automatic offer(input logic [1:0] act, input logic signed [31:0] exc,
                        input logic signed [31:0] teach, input logic signed [31:0] rstv,
                        input logic signed [31:0] inh, input logic signed [31:0] bias);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, bias, inh, rstv, teach, exc, act};
      req_live    = 1;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         req_live    = 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         // occasionally a long back-to-back stretch
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
      end
   endtask

   // Drop tvalid and wait until every expected response is back.
   // The extra edge lets the checker's count catch up with the last request.
   task automatic settle();
      if (req_live) begin
         req_tvalid <= 1'b0;
         req_live    = 0;
      end
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_neuron(input logic signed [31:0] rest,
                                 input logic signed [31:0] resetv,
                                 input logic signed [31:0] res,
                                 input logic [31:0] decay_raw,
                                 input logic signed [31:0] ofs,
                                 input logic [31:0] refr_raw);
      write_reg(lif_pkg::REG_REST_VOLTAGE, rest);
      write_reg(lif_pkg::REG_RESET_VOLTAGE, resetv);
      write_reg(lif_pkg::REG_MEMBRANE_RESISTANCE, res);
      write_reg(lif_pkg::REG_DECAY_FACTOR, decay_raw);
      write_reg(lif_pkg::REG_OFFSET_CURRENT, ofs);
      write_reg(lif_pkg::REG_REFRACTORY_STEPS, refr_raw);
      csr_we <= 1'b0;
   endtask

   // random s16.15 value between lo and hi whole units
   function automatic logic signed [31:0] q15_span(input int lo, input int hi);
      return int'($urandom_range(0, (hi - lo) * 32768)) + lo * 32768;
   endfunction

   // currents: mostly within +/-32.0, some full range, some edge values
   function automatic logic signed [31:0] pick_current();
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 4))
               0:       return S32_MAX;
               1:       return S32_MIN;
               2:       return 0;
               3:       return 1;
               default: return -1;
            endcase
         end
         default: return q15_span(-32, 32);
      endcase
   endfunction

   // teacher / reset channels: positive only now and then
   function automatic logic signed [31:0] pick_force();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(1, 32'h7FFF_FFFF);
         1:       return 1;
         2:       return pick_current();
         default: return 0;
      endcase
   endfunction

   function automatic logic [1:0] pick_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return lif_pkg::ACT_TIMESTEP;
      if (r < 80) return lif_pkg::ACT_SPIKED;
      if (r < 92) return lif_pkg::ACT_MARK;
      return ACT_UNUSED;
   endfunction

   // register settings for each random phase
   task automatic program_phase(input int phase);
      case (phase)
         0: program_neuron(q15_span(-70, -50), q15_span(-75, -60), q15_span(1, 10),
                           $urandom_range(16384, 32768), q15_span(-2, 2),
                           $urandom_range(0, 4));
         // everything at the top, decay well above one
         1: program_neuron(S32_MAX, S32_MAX, S32_MAX, 32'h0000_FFFF, S32_MAX,
                           32'h0000_FFFF);
         // everything at the bottom
         2: program_neuron(S32_MIN, S32_MIN, S32_MIN, 32'd0, S32_MIN, 32'd0);
         // decay exactly 1.0, negative resistance
         3: program_neuron(q15_span(-70, -50), q15_span(-75, -60), q15_span(-10, -1),
                           ONE_Q15, q15_span(-2, 2), $urandom_range(0, 4));
         // raw bits everywhere, plus a write to an index with no register
         4: begin
            write_reg(REG_UNMAPPED, $urandom);
            program_neuron($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end
         // decay slightly above one
         default: program_neuron(q15_span(-70, -50), q15_span(-75, -60), q15_span(1, 4),
                                 $urandom_range(32769, 40000), q15_span(-1, 1),
                                 $urandom_range(0, 2));
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Stimulus and verdict
   // ------------------------------------------------------------------------
   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      burst_left = 4;

      // rest -65.0, reset -70.0, R 2.0, decay ~0.885, offset 0.5, 3 refractory steps
      program_neuron(-65 * ONE_Q15, -70 * ONE_Q15, 2 * ONE_Q15, 32'd29000, ONE_Q15 / 2,
                     32'd3);

      // directed: plain step, then saturation of the net current both ways
      offer(lif_pkg::ACT_TIMESTEP, 0, 0, 0, 0, 0);
      offer(lif_pkg::ACT_TIMESTEP, S32_MAX, 0, 0, 0, 0);
      offer(lif_pkg::ACT_TIMESTEP, S32_MIN, 0, 0, S32_MAX, 0);
      offer(lif_pkg::ACT_TIMESTEP, 0, 0, 0, S32_MIN, S32_MAX);
      offer(lif_pkg::ACT_TIMESTEP, -1, 0, 0, 1, S32_MIN);
      // teacher forces the firing voltage
      offer(lif_pkg::ACT_TIMESTEP, ONE_Q15, 1, 0, 0, 0);
      // teacher and reset together: reset wins
      offer(lif_pkg::ACT_TIMESTEP, ONE_Q15, S32_MAX, 1, 0, 0);
      // reset drops a huge excitatory current
      offer(lif_pkg::ACT_TIMESTEP, S32_MAX, 0, S32_MAX, 0, ONE_Q15);
      // zero and negative forcing inputs do nothing
      offer(lif_pkg::ACT_TIMESTEP, 3 * ONE_Q15, 0, 0, 0, 0);
      offer(lif_pkg::ACT_TIMESTEP, ONE_Q15, S32_MIN, S32_MIN, 0, 0);
      offer(lif_pkg::ACT_TIMESTEP, ONE_Q15, -1, -1, -ONE_Q15, 0);
      offer(lif_pkg::ACT_MARK, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
      offer(ACT_UNUSED, S32_MIN, S32_MAX, -1, 1, S32_MIN);
      // spike, then three refractory steps (history still copied) and live ones, with marks between
      offer(lif_pkg::ACT_SPIKED, 0, 0, 0, 0, 0);
      offer(lif_pkg::ACT_TIMESTEP, ONE_Q15, 1, 0, 0, 0);
      offer(lif_pkg::ACT_TIMESTEP, ONE_Q15, 0, 1, 0, 0);
      offer(lif_pkg::ACT_MARK, 0, 0, 0, 0, 0);
      offer(lif_pkg::ACT_TIMESTEP, S32_MAX, 0, 0, 0, S32_MAX);
      offer(lif_pkg::ACT_TIMESTEP, 2 * ONE_Q15, 0, 0, 0, 0);
      offer(lif_pkg::ACT_TIMESTEP, 2 * ONE_Q15, 0, 0, 0, 0);
      offer(lif_pkg::ACT_MARK, 0, 0, 0, 0, 0);
      offer(lif_pkg::ACT_TIMESTEP, 0, 0, 0, 0, 0);
      settle();

      // random phases, each under its own register setting
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_phase(phase);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // one long response stall while requests keep coming
            if (phase == 0 && n == 90) hold_rsp = 1;
            offer(pick_action(), pick_current(), pick_force(), pick_force(),
                  pick_current(), pick_current());
         end
         settle();
      end

      // let any stray response show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_lif_neuron_teacher_step: done, clean");
      end else begin
         $display("tb_lif_neuron_teacher_step: done, errors");
      end
      $finish;
   end

endmodule
